/* hw/rtl/vups_pkg.sv */
// Package: shared types and constants for the pixel serializer.
package vups_pkg;

    localparam int PAL_ENTRIES = 16;
    localparam int COLOR_BITS  = 32;
    localparam int BASE_W      = 640;
    localparam int BASE_H      = 512;
    localparam int MAX_BORDER  = 16;

    // border width after reset and the matching end-of-buffer index
    localparam int BORDER_RESET = 4;
    localparam int RESET_END    = (BASE_W + 32 * BORDER_RESET) * (BASE_H + 32 * BORDER_RESET);

    localparam logic [31:0] BLACK_PIXEL = 32'hff00_0000;
    localparam logic [31:0] INVERT_BITS = 32'h00ff_ffff;
    localparam logic [COLOR_BITS-1:0] COLOR_MASK = {COLOR_BITS{1'b1}};

    typedef enum logic [3:0] {
        ACT_DATA    = 4'd0,
        ACT_BLANK   = 4'd1,
        ACT_HSYNC   = 4'd2,
        ACT_VSYNC   = 4'd3,
        ACT_CURSOR  = 4'd4,
        ACT_PALETTE = 4'd5,
        ACT_MODE    = 4'd6,
        ACT_ROWADDR = 4'd7,
        ACT_CURMASK = 4'd8
    } action_t;

    localparam logic [1:0] CFG_BORDER = 2'd0;
    localparam logic [1:0] CFG_DOUBLE = 2'd1;
    localparam logic [1:0] CFG_WOBBLE = 2'd2;

    // front end: recompute runs in two steps, multiplies registered, then compares
    typedef enum logic [1:0] {F_RUN, F_RC1, F_RC2} fstate_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  byte_value;
        logic [3:0]  sync_pulse_ticks;
        logic        interlace_compensate;
        logic [3:0]  palette_slot;
        logic [31:0] palette_color;
        logic [2:0]  mode_code;
        logic [4:0]  char_row;
        logic [3:0]  segment_mask;
    } in_item_t;

    typedef struct packed {
        logic [22:0] pixel_index;
        logic [31:0] pixel_color;
        logic        last_pixel;
        logic        frame_flyback;
    } out_item_t;

    // one job for the back end: a pixel run, a flyback marker or a palette write
    typedef struct packed {
        logic        flyback;
        logic        pal;
        logic        blank;
        logic        invert;
        logic        slow;
        logic [1:0]  lsel;      // 0: 8 logical px, 1: 4, 2: 2
        logic [7:0]  data;
        logic [22:0] base;
        logic [3:0]  slot;
        logic [31:0] color;
    } job_t;

endpackage

/* hw/rtl/vups_front.sv */
// Front end: beam tracking, window mapping and job issue.
module vups_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  vups_pkg::in_item_t in_item,
    output logic               job_valid,
    output vups_pkg::job_t     job,
    input  logic               job_full
);
    import vups_pkg::*;

    fstate_t     st_reg, st_next;
    logic [4:0]  border_reg;
    logic        dbl_reg, wob_reg;
    logic signed [16:0] hb_reg;
    logic [10:0] vb_reg;
    logic [22:0] wi_reg, rl_reg;
    logic [2:0]  cs_reg;
    logic [3:0]  cm_reg;
    logic [2:0]  mode_reg;
    logic        fb_reg;
    logic [22:0] end_reg, rowbase_reg;
    logic        vin_reg;

    logic [4:0]  b;
    logic [11:0] w, h;
    logic [9:0]  hs;
    logic [6:0]  vs;
    logic        slow;
    logic [4:0]  n;
    logic        accept;
    logic        fire;

    always_comb
    begin
        b    = (border_reg > 5'(MAX_BORDER)) ? 5'(MAX_BORDER) : border_reg;
        w    = (12'(BASE_W) + {b, 5'd0}) << dbl_reg;
        h    = (12'(BASE_H) + {b, 5'd0}) << dbl_reg;
        hs   = (b > 5'd15) ? 10'd0 : 10'({5'd15 - b, 4'd0});
        vs   = (b > 5'd4) ? 7'd0 : 7'({5'd4 - b, 4'd0});
        slow = (mode_reg >= 3'd3);
        n    = slow ? 5'd16 : 5'd8;
    end

    assign in_stall = (st_reg != F_RUN) || job_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            F_RUN: if (fire) st_next = F_RC1;
            F_RC1: st_next = F_RC2;
            F_RC2: st_next = F_RUN;
            default: st_next = F_RUN;
        endcase
    end

    // signals derived per item
    logic [16:0] hb_sum;
    logic        drawing;
    logic [16:0] hb_new;
    logic [10:0] vb_hs;
    logic signed [17:0] hrel;
    logic [11:0] vrel;

    always_comb
    begin
        hb_sum   = 17'(hb_reg + $signed({12'd0, n}));
        hb_new   = (hb_reg > $signed(17'd32767 - 17'(n))) ? 17'd32767 : hb_sum;
        drawing  = wi_reg < rl_reg;
        vb_hs    = vb_reg + 11'd2;
    end

    // outputs
    always_comb
    begin
        fire      = 1'b0;
        job_valid = 1'b0;
        job       = '0;
        if (cfg_we && cfg_index <= CFG_WOBBLE)
            fire = 1'b1;
        if (accept)
        begin
            priority case (in_item.action)
                ACT_DATA, ACT_BLANK:
                begin
                    if (drawing)
                    begin
                        job_valid  = 1'b1;
                        job.blank  = (in_item.action == ACT_BLANK) || fb_reg;
                        job.invert = (cs_reg < 3'd4) && cm_reg[cs_reg[1:0]];
                        job.slow   = slow;
                        job.lsel   = (mode_reg >= 3'd3) ? 2'(mode_reg - 3'd3)
                                                        : mode_reg[1:0];
                        job.data   = in_item.byte_value;
                        job.base   = wi_reg;
                    end
                    else if ((hb_new & ~17'(n - 5'd1)) == 17'(hs))
                        fire = 1'b1;
                end
                ACT_HSYNC:
                begin
                    fire = 1'b1;
                    if (vb_hs >= 11'd768)
                    begin
                        job_valid   = 1'b1;
                        job.flyback = 1'b1;
                    end
                end
                ACT_VSYNC:
                begin
                    fire        = 1'b1;
                    job_valid   = 1'b1;
                    job.flyback = 1'b1;
                end
                ACT_MODE:
                    fire = (in_item.mode_code <= 3'd5) && (in_item.mode_code != mode_reg);
                // palette writes queue behind earlier runs so those keep old colours
                ACT_PALETTE:
                begin
                    job_valid = 1'b1;
                    job.pal   = 1'b1;
                    job.slot  = in_item.palette_slot;
                    job.color = in_item.palette_color;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        hrel = $signed({hb_reg[16], hb_reg}) - $signed({8'd0, hs});
        vrel = 12'({1'b0, vb_reg} - {5'd0, vs});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= F_RUN;
            border_reg <= 5'(BORDER_RESET);
            dbl_reg    <= 1'b0;
            wob_reg    <= 1'b0;
            hb_reg     <= '0;
            vb_reg     <= '0;
            wi_reg     <= 23'(RESET_END);
            rl_reg     <= 23'(RESET_END);
            cs_reg     <= 3'd4;
            cm_reg     <= '0;
            mode_reg   <= '0;
            fb_reg     <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BORDER: border_reg <= cfg_data;
                    CFG_DOUBLE: dbl_reg    <= cfg_data[0];
                    CFG_WOBBLE: wob_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                priority case (in_item.action)
                    ACT_DATA, ACT_BLANK:
                    begin
                        hb_reg <= hb_new;
                        if (drawing)
                        begin
                            wi_reg <= wi_reg + 23'(n);
                            if (cs_reg < 3'd4)
                                cs_reg <= cs_reg + 3'd1;
                        end
                    end
                    ACT_HSYNC:
                    begin
                        hb_reg <= in_item.sync_pulse_ticks[0] ? -17'sd4 : 17'sd0;
                        // forced vsync: beam is at -4 or 0, so only wobble matters
                        if (vb_hs >= 11'd768)
                            vb_reg <= !wob_reg ? 11'd2 : 11'd0;
                        else
                            vb_reg <= vb_hs;
                    end
                    ACT_VSYNC:
                        vb_reg <= (in_item.interlace_compensate && !wob_reg
                                   && hb_reg < 17'sd512) ? 11'd2 : 11'd0;
                    ACT_CURSOR:  cs_reg <= 3'd0;
                    ACT_MODE:
                        if (in_item.mode_code <= 3'd5) mode_reg <= in_item.mode_code;
                    ACT_ROWADDR: fb_reg <= in_item.char_row[3];
                    ACT_CURMASK: cm_reg <= in_item.segment_mask;
                    default: ;
                endcase
            end
            if (st_reg == F_RC2)
            begin
                if (vin_reg && hrel >= 0 && hrel < $signed({6'd0, w}))
                begin
                    wi_reg <= rowbase_reg + 23'(hrel[16:0]);
                    rl_reg <= rowbase_reg + 23'(w) - 23'(n);
                end
                else
                begin
                    wi_reg <= end_reg;
                    rl_reg <= end_reg;
                end
            end
        end
    end

    // multiplier stage of the position recompute
    always_ff @(posedge clk)
    begin
        end_reg     <= 23'(w) * 23'(h);
        rowbase_reg <= 23'(vrel) * 23'(w);
        vin_reg     <= (vb_reg >= 11'(vs)) && ({1'b0, vb_reg} < 12'(vs) + h);
    end

endmodule

/* hw/rtl/vups_queue.sv */
// Job queue between the front and back ends.
module vups_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  vups_pkg::job_t wr_job,
    output logic           full,
    output logic           rd_valid,
    output vups_pkg::job_t rd_job,
    input  logic           rd_en
);
    import vups_pkg::*;

    job_t       mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full     = (cnt_reg == 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 2'd1;
            if (rd_en) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_en) - 3'(rd_en);
        end
    end

endmodule

/* hw/rtl/vups_back.sv */
// Back end: palette lookup and pixel run generation.
module vups_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  vups_pkg::job_t      job,
    output logic                job_take,
    output logic                out_valid,
    input  logic                out_stall,
    output vups_pkg::out_item_t out_item
);
    import vups_pkg::*;

    logic [31:0] pal_reg [PAL_ENTRIES];
    logic [3:0]  j_reg;
    logic [7:0]  sr_reg;
    logic [31:0] col_reg;
    logic        ov_reg;
    out_item_t   oi_reg;

    logic        adv;
    logic        pal_take;
    logic [4:0]  n;
    logic [3:0]  smask;
    logic        load;
    logic [7:0]  sr_cur;
    logic [3:0]  idx;
    logic [31:0] col;

    // palette writes need no output slot
    assign pal_take = job_valid && job.pal;
    assign adv      = job_valid && !job.pal && (!ov_reg || !out_stall);
    always_comb
    begin
        n = job.slow ? 5'd16 : 5'd8;
        // stride-1 mask: stride = n / logical
        unique case ({job.slow, job.lsel})
            3'b000: smask = 4'd0;
            3'b001: smask = 4'd1;
            3'b010: smask = 4'd3;
            3'b100: smask = 4'd1;
            3'b101: smask = 4'd3;
            3'b110: smask = 4'd7;
            default: smask = 4'd0;
        endcase
        load   = ((j_reg & smask) == 4'd0);
        sr_cur = (j_reg == 4'd0) ? job.data : sr_reg;
        idx    = {sr_cur[7], sr_cur[5], sr_cur[3], sr_cur[1]};
        if (job.blank)
            col = BLACK_PIXEL;
        else if (load)
            col = pal_reg[idx];
        else
            col = col_reg;
        job_take = pal_take || (adv && (job.flyback || (5'(j_reg) == n - 5'd1)));
    end

    always_ff @(posedge clk)
    begin
        if (adv && !job.flyback)
        begin
            col_reg <= col;
            if (load)
                sr_reg <= {sr_cur[6:0], 1'b1};
            else
                sr_reg <= sr_cur;
            oi_reg.pixel_index   <= job.base + 23'(j_reg);
            oi_reg.pixel_color   <= (job.invert ? (col ^ INVERT_BITS) : col)
                                    & COLOR_MASK;
            oi_reg.last_pixel    <= (5'(j_reg) == n - 5'd1);
            oi_reg.frame_flyback <= 1'b0;
        end
        else if (adv)
            oi_reg <= '{pixel_index: '0, pixel_color: '0,
                        last_pixel: 1'b0, frame_flyback: 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            j_reg  <= '0;
            for (int i = 0; i < PAL_ENTRIES; i++)
                pal_reg[i] <= '0;
        end
        else
        begin
            if (adv)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            if (job_take)
                j_reg <= '0;
            else if (adv)
                j_reg <= j_reg + 4'd1;
            if (pal_take)
                pal_reg[job.slot] <= job.color;
        end
    end

    assign out_valid = ov_reg;
    assign out_item  = oi_reg;

endmodule

/* hw/rtl/video_ula_pixel_serializer.sv */
// Top level of the pixel serializer: front end, job queue, back end.
// With the queue empty, a drawn byte's job is registered in the queue, then its
// first pixel in the back-end output register. Throughput: one host pixel per
// cycle unless the output stalls; a byte gives 8 (fast) or 16 (slow) pixels.
// A request that moves the window stalls the input while it is recomputed.
// Reset (rst_n, async): beam at origin, nothing drawn, cursor off, queue empty.
module video_ula_pixel_serializer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [4:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  vups_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output vups_pkg::out_item_t out_item
);
    import vups_pkg::*;

    // palette writes ride the queue too, so runs already queued keep their colours
    logic        fq_valid, q_full, q_valid, q_take;
    job_t        fq_job, q_job;

    vups_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .job_valid(fq_valid), .job(fq_job), .job_full(q_full)
    );

    vups_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_en(fq_valid), .wr_job(fq_job), .full(q_full),
        .rd_valid(q_valid), .rd_job(q_job), .rd_en(q_take)
    );

    vups_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job(q_job), .job_take(q_take),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the video ULA pixel serializer.
`timescale 1ns / 100ps

module testbench;
    import vups_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    localparam int SETTLE_CYCLES = 40;    // margin over the recompute stall of the input
    localparam int WATCHDOG_LIMIT = 6000; // idle cycles tolerated between acceptances
    localparam int MAX_REPORTS = 10;

    localparam logic [1:0] CFG_UNMAPPED = 2'd3;   // no register behind this index
    localparam logic [3:0] ACT_UNDEF    = 4'd12;  // action with no meaning

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    video_ula_pixel_serializer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // ------------------------------------------------------------------
    // Pending request list: input items, register writes and drains
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        REQ_ITEM,
        REQ_CFG,
        REQ_DRAIN   // hold off until every expected pixel has arrived
    } req_kind_t;

    typedef struct {
        req_kind_t  kind;
        in_item_t   item;
        logic [1:0] reg_idx;
        logic [4:0] reg_val;
    } req_t;

    req_t      pending_reqs[$];
    out_item_t expected_pixels[$];

    // ------------------------------------------------------------------
    // Pixel predictor: own copy of registers and beam state
    // ------------------------------------------------------------------
    logic [4:0]  p_border;
    logic        p_double;
    logic        p_wobble;
    logic [31:0] p_palette[PAL_ENTRIES];
    int          p_hbeam;
    int          p_vbeam;
    int          p_wr_idx;
    int          p_row_start;
    int          p_row_limit;
    int          p_cur_slot;     // 4 means cursor off
    logic [3:0]  p_cur_mask;
    logic [2:0]  p_mode;
    logic        p_blackout;

    function automatic int eff_border();
        return (p_border > MAX_BORDER) ? MAX_BORDER : int'(p_border);
    endfunction

    function automatic int canvas_w();
        return (BASE_W + eff_border() * 32) << p_double;
    endfunction

    function automatic int canvas_h();
        return (BASE_H + eff_border() * 32) << p_double;
    endfunction

    function automatic int win_hstart();
        return (eff_border() > 15) ? 0 : (15 - eff_border()) * 16;
    endfunction

    function automatic int win_vstart();
        return (eff_border() > 4) ? 0 : (4 - eff_border()) * 16;
    endfunction

    function automatic int run_len();
        return (p_mode >= 3) ? 16 : 8;
    endfunction

    // map the beam onto the frame buffer; off-window means nothing is drawn
    function automatic void recompute_pos();
        int w;
        int h;
        int hs;
        int vs;
        w = canvas_w();
        h = canvas_h();
        hs = win_hstart();
        vs = win_vstart();
        p_wr_idx = w * h;
        p_row_start = w * h;
        p_row_limit = w * h;
        if (p_vbeam >= vs + h || p_vbeam < vs)
            return;
        p_row_start = (p_vbeam - vs) * w;
        if (p_hbeam >= hs + w || p_hbeam < hs)
            return;
        p_wr_idx = p_row_start + p_hbeam - hs;
        p_row_limit = p_row_start + w - run_len();
    endfunction

    function automatic void push_flyback();
        out_item_t o;
        o = '0;
        o.frame_flyback = 1'b1;
        expected_pixels.push_back(o);
    endfunction

    function automatic void vsync_beam(logic compensate);
        p_vbeam = (compensate && !p_wobble && p_hbeam < 512) ? 2 : 0;
        recompute_pos();
    endfunction

    function automatic void draw_byte(logic [7:0] data, logic blank);
        int n;
        int stride;
        logic [7:0] sr;
        logic [31:0] colour;
        logic invert;
        out_item_t o;
        n = run_len();
        stride = n / (8 >> (p_mode % 3));
        sr = data;
        colour = '0;
        invert = 1'b0;
        if (p_hbeam > 32767 - n)
            p_hbeam = 32767;
        else
            p_hbeam += n;
        if (p_wr_idx >= p_row_limit)
        begin
            // off the visible row: re-sync when the beam reaches the window edge
            if ((p_hbeam & ~(n - 1)) == win_hstart())
                recompute_pos();
            return;
        end
        if (p_cur_slot < 4)
        begin
            invert = p_cur_mask[p_cur_slot];
            p_cur_slot++;
        end
        for (int j = 0; j < n; j++)
        begin
            if (blank || p_blackout)
                colour = BLACK_PIXEL;
            else if (j % stride == 0)
            begin
                colour = p_palette[{sr[7], sr[5], sr[3], sr[1]}];
                sr = {sr[6:0], 1'b1};
            end
            o.pixel_index = 23'(p_wr_idx + j);
            o.pixel_color = (invert ? (colour ^ INVERT_BITS) : colour) & COLOR_MASK;
            o.last_pixel = (j == n - 1);
            o.frame_flyback = 1'b0;
            expected_pixels.push_back(o);
        end
        p_wr_idx += n;
    endfunction

    function automatic void predict_request(in_item_t it);
        case (it.action)
            ACT_DATA:    draw_byte(it.byte_value, 1'b0);
            ACT_BLANK:   draw_byte(8'h00, 1'b1);
            ACT_HSYNC:
            begin
                p_hbeam = it.sync_pulse_ticks[0] ? -4 : 0;
                p_vbeam += 2;
                if (p_vbeam >= 768)
                begin
                    // forced flyback at the bottom of an over-long frame
                    push_flyback();
                    vsync_beam(1'b1);
                end
                recompute_pos();
            end
            ACT_VSYNC:
            begin
                push_flyback();
                vsync_beam(it.interlace_compensate);
            end
            ACT_CURSOR:  p_cur_slot = 0;
            ACT_PALETTE: p_palette[it.palette_slot] = it.palette_color;
            ACT_MODE:
            begin
                if (it.mode_code <= 3'd5 && it.mode_code != p_mode)
                begin
                    p_mode = it.mode_code;
                    recompute_pos();
                end
            end
            ACT_ROWADDR: p_blackout = it.char_row[3];
            ACT_CURMASK: p_cur_mask = it.segment_mask;
            default: ;
        endcase
    endfunction

    function automatic void apply_reg_write(logic [1:0] idx, logic [4:0] val);
        case (idx)
            CFG_BORDER: p_border = val;
            CFG_DOUBLE: p_double = val[0];
            CFG_WOBBLE: p_wobble = val[0];
            default:    return;   // unmapped index is ignored
        endcase
        recompute_pos();
    endfunction

    function automatic void predictor_reset();
        p_border = 5'd4;
        p_double = 1'b0;
        p_wobble = 1'b0;
        for (int i = 0; i < PAL_ENTRIES; i++)
            p_palette[i] = '0;
        p_hbeam = 0;
        p_vbeam = 0;
        p_cur_slot = 4;
        p_cur_mask = '0;
        p_mode = '0;
        p_blackout = 1'b0;
        p_wr_idx = canvas_w() * canvas_h();
        p_row_start = p_wr_idx;
        p_row_limit = p_wr_idx;
    endfunction

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    function automatic in_item_t noise_item();
        in_item_t it;
        it.action = 4'($urandom);
        it.byte_value = 8'($urandom);
        it.sync_pulse_ticks = 4'($urandom);
        it.interlace_compensate = 1'($urandom);
        it.palette_slot = 4'($urandom);
        it.palette_color = $urandom;
        it.mode_code = 3'($urandom);
        it.char_row = 5'($urandom);
        it.segment_mask = 4'($urandom);
        return it;
    endfunction

    // random content in every field, action forced
    function automatic void queue_op(action_t act);
        req_t r;
        r.kind = REQ_ITEM;
        r.item = noise_item();
        r.item.action = act;
        r.reg_idx = '0;
        r.reg_val = '0;
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_item(in_item_t it);
        req_t r;
        r.kind = REQ_ITEM;
        r.item = it;
        r.reg_idx = '0;
        r.reg_val = '0;
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_reg(logic [1:0] idx, logic [4:0] val);
        req_t r;
        r.kind = REQ_CFG;
        r.item = '0;
        r.reg_idx = idx;
        r.reg_val = val;
        pending_reqs.push_back(r);
    endfunction

    function automatic void queue_drain();
        req_t r;
        r.kind = REQ_DRAIN;
        r.item = '0;
        r.reg_idx = '0;
        r.reg_val = '0;
        pending_reqs.push_back(r);
    endfunction

    // one scan line: sync, some control, a run of screen bytes, sometimes a vsync or a random request
    function automatic void queue_line();
        int nbytes;
        pending_reqs.push_back('{REQ_ITEM, '0, '0, '0});
        pending_reqs[$].item = noise_item();
        pending_reqs[$].item.action = ACT_HSYNC;
        if ($urandom_range(0, 3) == 0)
            queue_op(ACT_MODE);
        if ($urandom_range(0, 2) == 0)
            queue_op(ACT_PALETTE);
        if ($urandom_range(0, 4) == 0)
        begin
            queue_op(ACT_CURMASK);
            queue_op(ACT_CURSOR);
        end
        if ($urandom_range(0, 4) == 0)
            queue_op(ACT_ROWADDR);
        // narrow borders need a longer run before the window opens
        nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 40)
                                             : $urandom_range(1, 10);
        for (int i = 0; i < nbytes; i++)
            queue_op(($urandom_range(0, 5) == 0) ? ACT_BLANK : ACT_DATA);
        if ($urandom_range(0, 9) == 0)
            queue_op(ACT_VSYNC);
        if ($urandom_range(0, 7) == 0)
            queue_item(noise_item());
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of requests with random gaps, register writes when idle
    // ------------------------------------------------------------------
    int   burst_left;
    int   gap_left;
    int   settle_cnt;
    logic drv_valid;
    logic drv_we;
    req_t drv_head;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            burst_left = 8;
            gap_left = 0;
            settle_cnt = 0;
        end
        else
        begin
            drv_valid = in_valid;
            drv_we = 1'b0;
            if (in_valid && !in_stall)
            begin
                predict_request(in_item);
                drv_valid = 1'b0;
            end
            if (expected_pixels.size() == 0 && !in_valid && !cfg_we)
                settle_cnt = settle_cnt + 1;
            else
                settle_cnt = 0;
            if (!drv_valid)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                else if (pending_reqs.size() > 0)
                begin
                    drv_head = pending_reqs[0];
                    case (drv_head.kind)
                        REQ_ITEM:
                        begin
                            in_item <= drv_head.item;
                            drv_valid = 1'b1;
                            void'(pending_reqs.pop_front());
                            burst_left = burst_left - 1;
                            if (burst_left <= 0)
                            begin
                                burst_left = $urandom_range(1, 24);
                                gap_left = ($urandom_range(0, 3) == 0)
                                           ? 0 : $urandom_range(1, 8);
                            end
                        end
                        REQ_CFG:
                        begin
                            if (settle_cnt >= SETTLE_CYCLES)
                            begin
                                cfg_index <= drv_head.reg_idx;
                                cfg_data <= drv_head.reg_val;
                                drv_we = 1'b1;
                                apply_reg_write(drv_head.reg_idx, drv_head.reg_val);
                                void'(pending_reqs.pop_front());
                                settle_cnt = 0;
                            end
                        end
                        default:
                        begin
                            if (settle_cnt >= SETTLE_CYCLES)
                                void'(pending_reqs.pop_front());
                        end
                    endcase
                end
            end
            in_valid <= drv_valid;
            cfg_we <= drv_we;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: stall pattern chosen at random among four, redrawn as stall_cnt counts cycles
    // ------------------------------------------------------------------
    int stall_cnt;
    int stall_style;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_cnt <= 0;
            stall_style <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 64 == 63)
                stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= stall_cnt[0];
                2:       out_stall <= ($urandom_range(0, 9) < 3);
                default: out_stall <= (stall_cnt % 8 < 5);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted pixel with the oldest expectation
    // ------------------------------------------------------------------
    int        mismatches;
    out_item_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < MAX_REPORTS)
                    $display("unexpected pixel: idx %0d colour %h last %b flyback %b",
                             out_item.pixel_index, out_item.pixel_color,
                             out_item.last_pixel, out_item.frame_flyback);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_item.pixel_index !== want.pixel_index
                    || out_item.pixel_color !== want.pixel_color
                    || out_item.last_pixel !== want.last_pixel
                    || out_item.frame_flyback !== want.frame_flyback)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: exp %0d %h %b %b, got %0d %h %b %b",
                                 want.pixel_index, want.pixel_color, want.last_pixel,
                                 want.frame_flyback, out_item.pixel_index,
                                 out_item.pixel_color, out_item.last_pixel,
                                 out_item.frame_flyback);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no request, register write or pixel accepted
    // ------------------------------------------------------------------
    int idle_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    in_item_t d;

    initial
    begin
        mismatches = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        predictor_reset();

        // directed: full-width border so pixels land straight after hsync
        queue_reg(CFG_BORDER, 5'd16);
        d = '0;
        d.action = ACT_PALETTE;
        d.palette_slot = 4'd0;
        d.palette_color = 32'h0000_0000;
        queue_item(d);
        d.palette_slot = 4'd15;
        d.palette_color = 32'hffff_ffff;
        queue_item(d);
        d.palette_slot = 4'd10;
        d.palette_color = 32'h1234_5678;
        queue_item(d);
        d = '0;
        d.action = ACT_HSYNC;
        queue_item(d);
        d = '0;
        d.action = ACT_DATA;
        d.byte_value = 8'h00;
        queue_item(d);
        d.byte_value = 8'hff;
        queue_item(d);
        d.byte_value = 8'haa;
        queue_item(d);
        queue_op(ACT_BLANK);
        d = '0;
        d.action = ACT_ROWADDR;
        d.char_row = 5'b01000;         // force black
        queue_item(d);
        queue_op(ACT_DATA);
        d.char_row = 5'b10111;
        queue_item(d);
        d = '0;
        d.action = ACT_CURMASK;
        d.segment_mask = 4'b1010;
        queue_item(d);
        queue_op(ACT_CURSOR);
        for (int i = 0; i < 5; i++)    // cursor runs out after four slots
            queue_op(ACT_DATA);
        d = '0;
        d.action = ACT_MODE;
        d.mode_code = 3'd6;            // unknown mode, ignored
        queue_item(d);
        d.mode_code = 3'd5;
        queue_item(d);
        queue_item(d);                 // same mode again
        d = '0;
        d.action = ACT_HSYNC;
        d.sync_pulse_ticks = 4'd15;    // odd pulse: beam starts at -4
        queue_item(d);
        queue_op(ACT_DATA);
        d = '0;
        d.action = ACT_VSYNC;
        d.interlace_compensate = 1'b1;
        queue_item(d);
        d = '0;
        d.action = ACT_UNDEF;
        queue_item(d);

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin queue_reg(CFG_BORDER, 5'd16); queue_reg(CFG_DOUBLE, 5'd0);
                         queue_reg(CFG_WOBBLE, 5'd0); end
                1: begin queue_reg(CFG_BORDER, 5'd31); queue_reg(CFG_WOBBLE, 5'd1);
                         queue_reg(CFG_UNMAPPED, 5'd7); end
                2: begin queue_reg(CFG_BORDER, 5'd0); queue_reg(CFG_DOUBLE, 5'd0); end
                3: begin queue_reg(CFG_BORDER, 5'd15); queue_reg(CFG_DOUBLE, 5'd1); end
                4: begin queue_reg(CFG_BORDER, 5'd4); queue_reg(CFG_DOUBLE, 5'd0);
                         queue_reg(CFG_WOBBLE, 5'd0); end
                5: begin queue_reg(CFG_BORDER, 5'd16); queue_reg(CFG_DOUBLE, 5'd31);
                         queue_reg(CFG_WOBBLE, 5'd31); end
                default: begin queue_reg(CFG_BORDER, 5'(2 + $urandom_range(0, 14)));
                         queue_reg(CFG_DOUBLE, 5'd0); end
            endcase
            queue_line();
            if (ph == 2)
                queue_drain();
            if (ph == 4)
            begin
                // long frame with no vsync: hsync alone forces the flyback
                for (int i = 0; i < 386; i++)
                    queue_op(ACT_HSYNC);
                queue_line();
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid || cfg_we || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
